// ----- rtl/eeg_df_pkg.sv -----
// eeg_df_pkg: constants and types shared by the packet deframer files.
// No dependencies.
package eeg_df_pkg;

  localparam int unsigned WIN_LEN     = 37;
  localparam int unsigned OUT_SAMPLES = 8;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HOLD_W      = 6;

  // Slot positions inside the window (slot 0 oldest)
  localparam int unsigned IDX_LEN  = 2;
  localparam int unsigned IDX_TIME = 3;
  localparam int unsigned IDX_DATA = 7;
  localparam int unsigned IDX_SUM  = 34;

  localparam logic [7:0] SOF_HI = 8'hAB;
  localparam logic [7:0] SOF_LO = 8'hCD;
  localparam logic [7:0] EOF_HI = 8'hDC;
  localparam logic [7:0] EOF_LO = 8'hBA;

  localparam logic [TIME_W-1:0] JUMP_RESET = 32'd10000;
  localparam logic [HOLD_W-1:0] HOLD_LOAD  = 6'(WIN_LEN);

  typedef logic [WIN_LEN-1:0][7:0] win_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [OUT_SAMPLES-1:0] sample_vec_t;

  typedef struct packed {
    logic frame_ok;    // markers and checksum all match
    logic time_jump;
    logic first_packet;
  } chk_status_t;

endpackage

// ----- rtl/eeg_df_if.sv -----
// eeg_df_if: valid/ready channel interfaces for received bytes and decoded packets.
// Depends on nothing; payload widths follow the decoded packet format.
interface eeg_df_byte_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface eeg_df_pkt_if (input logic clk);
  logic               valid;
  logic               ready;
  logic        [31:0] board_time;
  logic signed [23:0] sample_0;
  logic signed [23:0] sample_1;
  logic signed [23:0] sample_2;
  logic signed [23:0] sample_3;
  logic signed [23:0] sample_4;
  logic signed [23:0] sample_5;
  logic signed [23:0] sample_6;
  logic signed [23:0] sample_7;
  logic               time_jump;
  logic               first_packet;

  modport source (output valid, output board_time, output sample_0, output sample_1,
                  output sample_2, output sample_3, output sample_4, output sample_5,
                  output sample_6, output sample_7, output time_jump,
                  output first_packet, input ready);
  modport sink   (input valid, input board_time, input sample_0, input sample_1,
                  input sample_2, input sample_3, input sample_4, input sample_5,
                  input sample_6, input sample_7, input time_jump,
                  input first_packet, output ready);
endinterface

// ----- rtl/eeg_df_check.sv -----
// eeg_df_check: frame check and field extraction on the registered byte window.
// Depends on eeg_df_pkg.
module eeg_df_check #(
  parameter int unsigned CHANNELS = 8
) (
  input  eeg_df_pkg::win_t                      win,
  input  logic [7:0]                            sum,
  input  logic                                  seen,
  input  logic [eeg_df_pkg::TIME_W-1:0]         prev_time,
  input  logic [eeg_df_pkg::TIME_W-1:0]         threshold,
  output logic [eeg_df_pkg::TIME_W-1:0]         board_time,
  output eeg_df_pkg::sample_vec_t               samples,
  output eeg_df_pkg::chk_status_t               status
);

  logic [eeg_df_pkg::TIME_W:0]   diff_raw;
  logic [eeg_df_pkg::TIME_W-1:0] diff_abs;

  assign board_time = {win[eeg_df_pkg::IDX_TIME],     win[eeg_df_pkg::IDX_TIME + 1],
                       win[eeg_df_pkg::IDX_TIME + 2], win[eeg_df_pkg::IDX_TIME + 3]};

  for (genvar c = 0; c < eeg_df_pkg::OUT_SAMPLES; c++) begin : g_smp
    if (c < CHANNELS) begin : g_on
      assign samples[c] = {win[eeg_df_pkg::IDX_DATA + 3*c],
                           win[eeg_df_pkg::IDX_DATA + 3*c + 1],
                           win[eeg_df_pkg::IDX_DATA + 3*c + 2]};
    end else begin : g_off
      assign samples[c] = '0;
    end
  end

  // Absolute timestamp difference from one 33-bit subtract
  assign diff_raw = {1'b0, board_time} - {1'b0, prev_time};
  assign diff_abs = diff_raw[eeg_df_pkg::TIME_W] ? (~diff_raw[eeg_df_pkg::TIME_W-1:0] + 1'b1)
                                                 : diff_raw[eeg_df_pkg::TIME_W-1:0];

  always_comb begin
    status.frame_ok = (win[0] == eeg_df_pkg::SOF_HI) &&
                      (win[1] == eeg_df_pkg::SOF_LO) &&
                      (win[eeg_df_pkg::WIN_LEN-2] == eeg_df_pkg::EOF_HI) &&
                      (win[eeg_df_pkg::WIN_LEN-1] == eeg_df_pkg::EOF_LO) &&
                      (win[eeg_df_pkg::IDX_SUM] == sum);
    status.time_jump    = seen && (diff_abs > threshold);
    status.first_packet = !seen;
  end

endmodule

// ----- rtl/eeg_packet_deframer_core.sv -----
// eeg_packet_deframer_core: top level of the serial packet deframer.
// Depends on eeg_df_pkg, eeg_df_if (byte and packet channels) and eeg_df_check.
//
// Each received byte is shifted into a 37-byte window register together with a
// running 8-bit checksum of window slots 2..33, so no adder tree is needed. The
// registered window is then checked for the 0xAB 0xCD start marker, the 0xDC 0xBA
// end marker, the checksum byte and the 37-byte holdoff since the last packet; on
// a hit the timestamp, the samples and the jump and first-packet flags are loaded
// into the output register. A byte is taken every cycle while the output register
// is free or being drained, so the sustained rate is one byte per clock. Channels
// at or above CHANNELS read as zero. jump_threshold (cfg_wdata, reset 10000) is
// written when cfg_we is high; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module eeg_packet_deframer_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  eeg_df_byte_if.sink           in_ch,
  eeg_df_pkt_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata
);

  // Stage 1: byte window and running checksum
  eeg_df_pkg::win_t                 win_r, win_nxt;
  logic [7:0]                       sum_r, sum_nxt;
  logic                             fresh_r;   // window holds an unchecked transaction

  // Stage 2: packet tracking and output register
  logic [eeg_df_pkg::HOLD_W-1:0]    hold_r;
  logic [eeg_df_pkg::HOLD_W-1:0]    hold_dec;
  logic [eeg_df_pkg::TIME_W-1:0]    prev_time_r;
  logic                             seen_r;
  logic [eeg_df_pkg::TIME_W-1:0]    thresh_r;
  logic                             out_valid_r;
  logic [eeg_df_pkg::TIME_W-1:0]    out_time_r;
  eeg_df_pkg::sample_vec_t          out_smp_r;
  logic                             out_jump_r;
  logic                             out_first_r;

  logic                             in_take;
  logic                             adv;
  logic                             hit;
  logic [eeg_df_pkg::TIME_W-1:0]    chk_time;
  eeg_df_pkg::sample_vec_t          chk_smp;
  eeg_df_pkg::chk_status_t          chk_st;

  // Advance the check stage when the output register can take its result
  assign adv     = fresh_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !fresh_r || adv;

  // Shift in the new byte; the slot leaving the checksum range is slot 2,
  // the one entering it is old slot 34
  always_comb begin
    win_nxt = {in_ch.rx_byte, win_r[eeg_df_pkg::WIN_LEN-1:1]};
    sum_nxt = sum_r - win_r[eeg_df_pkg::IDX_LEN] + win_r[eeg_df_pkg::IDX_SUM];
  end

  eeg_df_check #(.CHANNELS(CHANNELS)) u_check (
    .win        (win_r),
    .sum        (sum_r),
    .seen       (seen_r),
    .prev_time  (prev_time_r),
    .threshold  (thresh_r),
    .board_time (chk_time),
    .samples    (chk_smp),
    .status     (chk_st)
  );

  assign hold_dec = (hold_r != '0) ? hold_r - 1'b1 : hold_r;
  assign hit      = chk_st.frame_ok && (hold_dec == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      sum_r       <= '0;
      fresh_r     <= 1'b0;
      hold_r      <= '0;
      prev_time_r <= '0;
      seen_r      <= 1'b0;
      thresh_r    <= eeg_df_pkg::JUMP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (in_take) begin
        win_r <= win_nxt;
        sum_r <= sum_nxt;
      end
      fresh_r <= in_take || (fresh_r && !adv);
      if (adv) begin
        out_valid_r <= hit;
        if (hit) begin
          hold_r      <= eeg_df_pkg::HOLD_LOAD;
          prev_time_r <= chk_time;
          seen_r      <= 1'b1;
        end else begin
          hold_r <= hold_dec;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: load only with a new packet
  always_ff @(posedge clk) begin
    if (adv && hit) begin
      out_time_r  <= chk_time;
      out_smp_r   <= chk_smp;
      out_jump_r  <= chk_st.time_jump;
      out_first_r <= chk_st.first_packet;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.board_time   = out_time_r;
  assign out_ch.sample_0     = out_smp_r[0];
  assign out_ch.sample_1     = out_smp_r[1];
  assign out_ch.sample_2     = out_smp_r[2];
  assign out_ch.sample_3     = out_smp_r[3];
  assign out_ch.sample_4     = out_smp_r[4];
  assign out_ch.sample_5     = out_smp_r[5];
  assign out_ch.sample_6     = out_smp_r[6];
  assign out_ch.sample_7     = out_smp_r[7];
  assign out_ch.time_jump    = out_jump_r;
  assign out_ch.first_packet = out_first_r;

endmodule

// ----- rtl/eeg_df_checker.sv -----
// eeg_df_checker: port-level assertions for the packet deframer, bound to the top level.
// Depends on eeg_packet_deframer_core.
module eeg_df_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] board_time,
  input logic        time_jump,
  input logic        first_packet
);

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled packet holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(board_time))
    else $error("stalled packet changed");

  // The first packet never carries a jump
  a_first_no_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_packet |-> !time_jump)
    else $error("jump flagged on first packet");

  // Packets are spaced by the holdoff, so none follows a transaction at once
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("packets too close together");

endmodule

bind eeg_packet_deframer_core eeg_df_checker u_df_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .board_time   (out_ch.board_time),
  .time_jump    (out_ch.time_jump),
  .first_packet (out_ch.first_packet)
);

// ----- test/eeg_packet_deframer_core_test.sv -----
// eeg_packet_deframer_core_test: self-checking bench for the serial packet deframer.
// Depends on eeg_df_pkg, eeg_df_byte_if, eeg_df_pkt_if and eeg_packet_deframer_core.
// Feeds byte streams of framed packets, broken frames and noise; checks every decoded packet.
`timescale 1ns / 100ps

module eeg_packet_deframer_core_test;

  localparam int unsigned N_CH           = 8;
  localparam logic [7:0]  FRAME_LEN_BYTE = 8'd27;
  localparam int          PRESSURE_HOLD  = 300;   // receiver hold-off, in cycles
  localparam int          WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int          DRAIN_CYCLES   = 8;     // window check plus output register

  // Ways to spoil a frame on purpose
  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_SOF, FLAW_EOF, FLAW_SHORT} flaw_e;

  // One decoded packet, as seen on the output channel
  typedef struct packed {
    logic [eeg_df_pkg::TIME_W-1:0] board_time;
    eeg_df_pkg::sample_vec_t       samples;
    logic                          time_jump;
    logic                          first_packet;
  } packet_fields_t;

  // Tracks the byte window like the block does, queues the packets that the
  // accepted bytes must produce, and checks decoded packets against them.
  class packet_tracker;
    logic [7:0]                    win [eeg_df_pkg::WIN_LEN];
    logic [eeg_df_pkg::HOLD_W-1:0] holdoff;
    logic [eeg_df_pkg::TIME_W-1:0] last_time;
    bit                            seen;
    logic [eeg_df_pkg::TIME_W-1:0] threshold;
    packet_fields_t                pending_packets[$];
    int                            packets_expected;
    int                            packets_checked;
    int                            jumps_seen;
    int                            mismatches;

    function new();
      foreach (win[i]) win[i] = 8'h00;
      holdoff   = '0;
      last_time = '0;
      seen      = 1'b0;
      threshold = eeg_df_pkg::JUMP_RESET;
    endfunction

    // Shift one accepted byte in; queue a packet when the window decodes.
    function void note_byte(logic [7:0] rx);
      packet_fields_t                pkt;
      logic [7:0]                    sum;
      logic [eeg_df_pkg::TIME_W-1:0] gap;
      int                            i;
      for (i = 0; i < eeg_df_pkg::WIN_LEN - 1; i++) win[i] = win[i+1];
      win[eeg_df_pkg::WIN_LEN-1] = rx;
      if (holdoff != 0) holdoff--;
      if (holdoff != 0) return;
      if (win[0] != eeg_df_pkg::SOF_HI || win[1] != eeg_df_pkg::SOF_LO) return;
      if (win[eeg_df_pkg::WIN_LEN-2] != eeg_df_pkg::EOF_HI ||
          win[eeg_df_pkg::WIN_LEN-1] != eeg_df_pkg::EOF_LO) return;
      sum = 8'h00;
      for (i = eeg_df_pkg::IDX_LEN; i < eeg_df_pkg::IDX_SUM; i++) sum += win[i];
      if (win[eeg_df_pkg::IDX_SUM] != sum) return;
      pkt.board_time = {win[eeg_df_pkg::IDX_TIME],     win[eeg_df_pkg::IDX_TIME+1],
                        win[eeg_df_pkg::IDX_TIME+2],   win[eeg_df_pkg::IDX_TIME+3]};
      for (i = 0; i < eeg_df_pkg::OUT_SAMPLES; i++) begin
        if (i < N_CH)
          pkt.samples[i] = {win[eeg_df_pkg::IDX_DATA+3*i], win[eeg_df_pkg::IDX_DATA+3*i+1],
                            win[eeg_df_pkg::IDX_DATA+3*i+2]};
        else
          pkt.samples[i] = '0;
      end
      gap = (pkt.board_time >= last_time) ? pkt.board_time - last_time
                                          : last_time - pkt.board_time;
      pkt.time_jump    = seen && (gap > threshold);
      pkt.first_packet = !seen;
      last_time = pkt.board_time;
      seen      = 1'b1;
      holdoff   = eeg_df_pkg::HOLD_LOAD;
      pending_packets.push_back(pkt);
      packets_expected++;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("packet %0d: %0s expected %h, got %h", packets_checked, what, want, got);
    endfunction

    // Compare a decoded packet with the oldest queued one, field by field.
    function void check_packet(packet_fields_t got);
      packet_fields_t want;
      int             c;
      if (pending_packets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected packet, board_time %h", got.board_time);
        return;
      end
      want = pending_packets.pop_front();
      packets_checked++;
      if (got.board_time !== want.board_time)
        flag("board_time", want.board_time, got.board_time);
      for (c = 0; c < eeg_df_pkg::OUT_SAMPLES; c++)
        if (got.samples[c] !== want.samples[c])
          flag($sformatf("sample_%0d", c), {8'h00, want.samples[c]}, {8'h00, got.samples[c]});
      if (got.time_jump !== want.time_jump)
        flag("time_jump", want.time_jump, got.time_jump);
      if (got.first_packet !== want.first_packet)
        flag("first_packet", want.first_packet, got.first_packet);
      if (want.time_jump) jumps_seen++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  eeg_df_byte_if in_ch (clk);
  eeg_df_pkt_if  out_ch (clk);

  eeg_packet_deframer_core #(.CHANNELS(N_CH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  packet_tracker board = new();

  int         bytes_sent;      // bytes offered so far (driver side)
  int         bytes_taken;     // byte transactions seen at the clock edge
  int         send_idle_pct;   // chance per cycle that the sender holds off
  int         recv_stall_pct;  // chance per cycle that the receiver stalls
  int         hold_requests;   // long receiver hold-offs asked for
  int         settings_used;   // threshold writes done
  logic [7:0] frame [eeg_df_pkg::WIN_LEN]; // frame under construction

  // Clock: 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drive ready at the falling edge. Random stalls per the current
  // phase; a requested hold-off keeps ready low for a long counted stretch so
  // the block fills up and has to push back on the byte channel.
  initial begin : drive_ready
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_requests != holds_served) begin
        holds_served++;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: sample both channels at the rising edge. Feed every accepted
  // byte to the tracker, and check every accepted packet against it.
  always @(posedge clk) begin : watch_ports
    packet_fields_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        board.note_byte(in_ch.rx_byte);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.board_time   = out_ch.board_time;
        got.samples[0]   = out_ch.sample_0;
        got.samples[1]   = out_ch.sample_1;
        got.samples[2]   = out_ch.sample_2;
        got.samples[3]   = out_ch.sample_3;
        got.samples[4]   = out_ch.sample_4;
        got.samples[5]   = out_ch.sample_5;
        got.samples[6]   = out_ch.sample_6;
        got.samples[7]   = out_ch.sample_7;
        got.time_jump    = out_ch.time_jump;
        got.first_packet = out_ch.first_packet;
        board.check_packet(got);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel; give up
  // when the count reaches the limit.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d packets still pending",
               quiet, board.pending_packets.size());
      $display("[eeg_packet_deframer_core] ERROR");
      $finish;
    end
  end

  // Offer one byte; enter and leave at a falling edge. Idle cycles go before
  // the byte, and valid is only touched once per edge.
  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= value;
    bytes_sent++;
    // hold the byte until the monitor has seen the transaction
    do @(negedge clk); while (bytes_taken != bytes_sent);
  endtask

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 4) == 0)
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return 8'h80;
        default: return 8'h7F;
      endcase
    return 8'($urandom_range(0, 255));
  endfunction

  // Noise leans toward marker bytes so that false starts show up often.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 3) == 0)
      case ($urandom_range(0, 3))
        0:       return eeg_df_pkg::SOF_HI;
        1:       return eeg_df_pkg::SOF_LO;
        2:       return eeg_df_pkg::EOF_HI;
        default: return eeg_df_pkg::EOF_LO;
      endcase
    return 8'($urandom_range(0, 255));
  endfunction

  // Recompute the checksum byte over the length byte and the payload.
  function automatic void seal_frame();
    logic [7:0] sum;
    int         i;
    sum = 8'h00;
    for (i = eeg_df_pkg::IDX_LEN; i < eeg_df_pkg::IDX_SUM; i++) sum += frame[i];
    frame[eeg_df_pkg::IDX_SUM] = sum;
  endfunction

  // Build a well-formed frame with random samples and spare bytes.
  function automatic void build_frame(input logic [31:0] stamp);
    int i;
    frame[0]                   = eeg_df_pkg::SOF_HI;
    frame[1]                   = eeg_df_pkg::SOF_LO;
    frame[eeg_df_pkg::IDX_LEN] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                             : FRAME_LEN_BYTE;
    for (i = eeg_df_pkg::IDX_DATA; i < eeg_df_pkg::IDX_SUM; i++) frame[i] = payload_byte();
    frame[eeg_df_pkg::IDX_TIME]     = stamp[31:24];
    frame[eeg_df_pkg::IDX_TIME+1]   = stamp[23:16];
    frame[eeg_df_pkg::IDX_TIME+2]   = stamp[15:8];
    frame[eeg_df_pkg::IDX_TIME+3]   = stamp[7:0];
    frame[eeg_df_pkg::WIN_LEN-2]    = eeg_df_pkg::EOF_HI;
    frame[eeg_df_pkg::WIN_LEN-1]    = eeg_df_pkg::EOF_LO;
    seal_frame();
  endfunction

  function automatic void put_sample(input int ch, input logic [23:0] value);
    frame[eeg_df_pkg::IDX_DATA+3*ch]   = value[23:16];
    frame[eeg_df_pkg::IDX_DATA+3*ch+1] = value[15:8];
    frame[eeg_df_pkg::IDX_DATA+3*ch+2] = value[7:0];
  endfunction

  // Pick a timestamp around the jump threshold of the last decoded packet.
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(0, 6))
      0:       return board.last_time + 32'($urandom_range(0, 1000));
      1:       return board.last_time + board.threshold;
      2:       return board.last_time + board.threshold + 32'd1;
      3:       return board.last_time - board.threshold;
      4:       return board.last_time - board.threshold - 32'd1;
      5:       return board.last_time - 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  // Spoil the frame as asked, then send it (or only its head when cut short).
  task automatic send_frame(input flaw_e flaw);
    int i;
    int stop_at;
    stop_at = eeg_df_pkg::WIN_LEN - 1;
    case (flaw)
      FLAW_SUM:   frame[eeg_df_pkg::IDX_SUM] ^= 8'(1 << $urandom_range(0, 7));
      FLAW_SOF:   frame[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FLAW_EOF:   frame[eeg_df_pkg::WIN_LEN - 1 - $urandom_range(0, 1)] ^=
                    8'($urandom_range(1, 255));
      FLAW_SHORT: stop_at = $urandom_range(1, eeg_df_pkg::WIN_LEN - 2);
      default:    ;
    endcase
    for (i = 0; i <= stop_at; i++) send_byte(frame[i]);
  endtask

  // Send a good frame with a start marker buried in its payload, then finish
  // a second frame that begins at that marker. The second window is valid in
  // itself but overlaps the first packet, so no packet may come out of it.
  task automatic send_overlap(input logic [31:0] stamp);
    int shift;
    int j;
    shift = $urandom_range(eeg_df_pkg::IDX_TIME, eeg_df_pkg::IDX_SUM - 2);
    build_frame(stamp);
    frame[shift]   = eeg_df_pkg::SOF_HI;
    frame[shift+1] = eeg_df_pkg::SOF_LO;
    seal_frame();
    send_frame(FLAW_NONE);
    for (j = 0; j < eeg_df_pkg::WIN_LEN - shift; j++) frame[j] = frame[shift+j];
    for (j = eeg_df_pkg::WIN_LEN - shift; j < eeg_df_pkg::IDX_SUM; j++)
      frame[j] = payload_byte();
    frame[eeg_df_pkg::WIN_LEN-2] = eeg_df_pkg::EOF_HI;
    frame[eeg_df_pkg::WIN_LEN-1] = eeg_df_pkg::EOF_LO;
    seal_frame();
    for (j = eeg_df_pkg::WIN_LEN - shift; j < eeg_df_pkg::WIN_LEN; j++) send_byte(frame[j]);
  endtask

  // Drop valid, wait for every queued packet, then let the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending_packets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.threshold = value;
    settings_used++;
  endtask

  // Directed part: reset threshold, first packet, sample and time extremes,
  // the threshold boundary both ways, each kind of broken frame, checksum
  // wrap-around, length byte extremes and an overlapping candidate.
  task automatic run_directed();
    int i;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(eeg_df_pkg::SOF_HI);
    send_byte(eeg_df_pkg::SOF_LO);
    send_byte(8'h5A);
    // first packet after reset: zero time, zero length byte, sample extremes
    build_frame(32'h0000_0000);
    frame[eeg_df_pkg::IDX_LEN] = 8'h00;
    put_sample(0, 24'h800000);
    put_sample(1, 24'h7FFFFF);
    put_sample(2, 24'h000000);
    put_sample(3, 24'hFFFFFF);
    put_sample(4, 24'h000001);
    put_sample(5, 24'h800001);
    put_sample(6, 24'h555555);
    put_sample(7, 24'hAAAAAA);
    seal_frame();
    send_frame(FLAW_NONE);
    // back to back; difference equal to the threshold is no jump
    build_frame(eeg_df_pkg::JUMP_RESET);
    frame[eeg_df_pkg::IDX_LEN] = 8'hFF;
    seal_frame();
    send_frame(FLAW_NONE);
    // one above the threshold is a jump
    build_frame(32'd20001);
    send_frame(FLAW_NONE);
    build_frame(32'hFFFF_FFFF);
    send_frame(FLAW_NONE);
    // downward by exactly the threshold
    build_frame(32'hFFFF_FFFF - eeg_df_pkg::JUMP_RESET);
    send_frame(FLAW_NONE);
    // each way of breaking a frame, then a good one right after
    build_frame($urandom);
    send_frame(FLAW_SUM);
    build_frame($urandom);
    send_frame(FLAW_SOF);
    build_frame($urandom);
    send_frame(FLAW_EOF);
    build_frame($urandom);
    send_frame(FLAW_SHORT);
    // all-ones payload wraps the checksum many times
    build_frame(32'hFFFF_FFFF);
    for (i = eeg_df_pkg::IDX_DATA; i < eeg_df_pkg::IDX_SUM; i++) frame[i] = 8'hFF;
    seal_frame();
    send_frame(FLAW_NONE);
    send_overlap($urandom);
    build_frame(next_stamp());
    send_frame(FLAW_NONE);
  endtask

  // Random part: mostly good frames with random content, some broken ones,
  // overlapping candidates and noise bursts between them.
  task automatic random_traffic(input int min_bytes, input int min_packets);
    int first_byte;
    int first_pkt;
    int pick;
    int burst;
    int i;
    first_byte = bytes_sent;
    first_pkt  = board.packets_expected;
    while (bytes_sent - first_byte < min_bytes ||
           board.packets_expected - first_pkt < min_packets) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_frame(next_stamp());
        send_frame(FLAW_NONE);
      end else if (pick < 80) begin
        build_frame(next_stamp());
        send_frame(flaw_e'($urandom_range(FLAW_SUM, FLAW_SHORT)));
      end else if (pick < 88) begin
        send_overlap(next_stamp());
      end else begin
        burst = $urandom_range(1, 40);
        for (i = 0; i < burst; i++) send_byte(noise_byte());
      end
    end
  endtask

  // One phase: go idle, write the threshold, set the idling mix, optionally
  // squeeze the block with a long receiver hold-off, then run random traffic.
  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [31:0] thr, input bit squeeze);
    int i;
    settle();
    write_threshold(thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) begin
      hold_requests <= hold_requests + 1;
      for (i = 0; i < 6; i++) begin
        build_frame(next_stamp());
        send_frame(FLAW_NONE);
      end
    end
    random_traffic(140, 3);
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    bytes_sent     = 0;
    bytes_taken    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    settings_used  = 0;
    // hold reset, release at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_phase(0, 0, 32'h0000_0000, 1'b1);
    run_phase(58, 0, 32'hFFFF_FFFF, 1'b0);
    run_phase(0, 58, 32'($urandom_range(1, 50000)), 1'b0);
    run_phase(9, 9, $urandom, 1'b0);
    settle();

    $display("run covered %0d bytes, %0d packets checked (%0d with a time jump)",
             bytes_taken, board.packets_checked, board.jumps_seen);
    $display("over %0d threshold writes, four idling mixes and a %0d-cycle output hold-off",
             settings_used, PRESSURE_HOLD);
    if (board.mismatches == 0 && board.pending_packets.size() == 0) begin
      $display("[eeg_packet_deframer_core] OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[eeg_packet_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
